@@ src/tsdc_pkg.sv @@
// shared types and constants of the tilt steered drive controller
package tsdc_pkg;

  localparam int SERVO_MID      = 2764;
  localparam int SERVO_HI       = 3474;
  localparam int PW_LEFT        = 2384;
  localparam int PW_MIN         = 2027;
  localparam int PW_NEUT        = 2764;
  localparam int MOVE_MARGIN    = 100;
  localparam int BUZZ_ON_TICKS  = 25;
  localparam int BUZZ_OFF_TICKS = 50;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [1:0] LAST_SAMPLE = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_TILT_GAIN = 3'd0,
    REG_STEER_GAIN  = 3'd1,
    REG_OFFSET_X    = 3'd2,
    REG_OFFSET_Y    = 3'd3
  } tsdc_reg_t;

  typedef enum logic {
    FUNC_SAMPLE = 1'b0,
    FUNC_TICK   = 1'b1
  } tsdc_func_t;

  typedef struct packed {
    logic              func;
    logic signed [7:0] accel_x_high;
    logic signed [7:0] accel_y_high;
    logic [7:0]        pot_level;
    logic              drive_disable;
  } tsdc_in_t;

  typedef struct packed {
    logic        kind;
    logic [11:0] servo_width;
    logic [11:0] drive_width;
    logic        is_moving;
    logic        buzzer_sounding;
  } tsdc_out_t;

  typedef struct packed {
    logic [5:0]  x_tilt_gain;
    logic [11:0] steer_gain_q8_8;
    logic [9:0]  offset_x;
    logic [9:0]  offset_y;
  } tsdc_cfg_t;

endpackage

@@ src/tsdc_calc.sv @@
// pulse width arithmetic: tilt, steering width, drive width and moving decision
module tsdc_calc (
  input  tsdc_pkg::tsdc_cfg_t cfg,
  input  logic signed [11:0]  sx,
  input  logic signed [11:0]  sy,
  input  logic [7:0]          pot_level,
  output logic [11:0]         servo_width,
  output logic [11:0]         drive_width,
  output logic                below_move
);

  logic signed [14:0] tx;
  logic signed [14:0] ty;
  logic [14:0]        atx;
  logic signed [27:0] steer_prod;
  logic signed [27:0] steer_bias;
  logic signed [19:0] steer_q;
  logic signed [21:0] servo_w;
  logic [13:0]        pot_mul;
  logic [5:0]         ky;
  logic signed [21:0] ky_ty;
  logic [20:0]        x_prod;
  logic signed [23:0] drive_w;

  // tilt = four times the sum, less the level offset
  assign tx = $signed({sx[11], sx, 2'b00}) - $signed({{5{cfg.offset_x[9]}}, cfg.offset_x});
  assign ty = $signed({sy[11], sy, 2'b00}) - $signed({{5{cfg.offset_y[9]}}, cfg.offset_y});
  assign atx = tx[14] ? 15'(-tx) : 15'(tx);

  // steering: q8.8 product, divided by 256 rounding toward zero
  assign steer_prod = $signed({1'b0, cfg.steer_gain_q8_8}) * tx;
  assign steer_bias = steer_prod + (steer_prod[27] ? 28'sd255 : 28'sd0);
  assign steer_q    = steer_bias[27:8];
  assign servo_w    = 22'(tsdc_pkg::SERVO_MID) - {{2{steer_q[19]}}, steer_q};

  always_comb begin
    if (servo_w > 22'(tsdc_pkg::SERVO_HI)) begin
      servo_width = 12'(tsdc_pkg::SERVO_HI);
    end else if (servo_w < 22'(tsdc_pkg::PW_LEFT)) begin
      servo_width = 12'(tsdc_pkg::PW_LEFT);
    end else begin
      servo_width = servo_w[11:0];
    end
  end

  // drive: y gain from the pot, less side tilt penalty
  assign pot_mul = 14'(pot_level) * 14'd50;
  assign ky      = pot_mul[13:8] + 6'd1;
  assign ky_ty   = $signed({1'b0, ky}) * ty;
  assign x_prod  = 21'(cfg.x_tilt_gain) * 21'(atx);
  assign drive_w = 24'(tsdc_pkg::PW_NEUT) + {{2{ky_ty[21]}}, ky_ty} - $signed({3'b000, x_prod});

  always_comb begin
    if (drive_w > 24'(tsdc_pkg::PW_NEUT)) begin
      drive_width = 12'(tsdc_pkg::PW_NEUT);
    end else if (drive_w < 24'(tsdc_pkg::PW_MIN)) begin
      drive_width = 12'(tsdc_pkg::PW_MIN);
    end else begin
      drive_width = drive_w[11:0];
    end
  end

  assign below_move = drive_width < 12'(tsdc_pkg::PW_NEUT - tsdc_pkg::MOVE_MARGIN);

endmodule

@@ src/tilt_steer_drive_controller.sv @@
// top level of the tilt steered drive controller
// Takes one transaction every clock cycle, accelerometer samples and 20 ms ticks alike; a
// result appears in the output register in the cycle after the transaction that causes it
// (the fourth sample of each group, or any tick), and the input stalls only while that
// register holds a result that the receiver stalls. The accumulation, the pulse width
// arithmetic (four small multipliers and their clamps) and the buzzer counter all settle
// combinationally between acceptance and the output register. Configuration writes
// are always ready and take effect on the next sample.
module tilt_steer_drive_controller (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  tsdc_pkg::tsdc_in_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output tsdc_pkg::tsdc_out_t                  out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tsdc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tsdc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  tsdc_pkg::tsdc_cfg_t cfg_r;

  logic [1:0]  sample_count_r, sample_count_nxt;
  logic [10:0] sum_x_r, sum_x_nxt;
  logic [10:0] sum_y_r, sum_y_nxt;
  logic        moving_r, moving_nxt;
  logic        phase_on_r, phase_on_nxt;
  logic [5:0]  buzz_ticks_r, buzz_ticks_nxt;
  logic        buzz_r, buzz_nxt;
  logic [11:0] last_servo_r, last_servo_nxt;
  logic [11:0] last_drive_r, last_drive_nxt;
  logic        out_valid_r, out_valid_nxt;
  tsdc_pkg::tsdc_out_t out_data_r, out_data_nxt;

  logic               in_accept;
  logic signed [11:0] sx;
  logic signed [11:0] sy;
  logic [11:0]        servo_calc;
  logic [11:0]        drive_calc;
  logic               below_move;
  logic [5:0]         ticks_inc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_tilt_gain     <= '0;
      cfg_r.steer_gain_q8_8 <= 12'd512;
      cfg_r.offset_x        <= '0;
      cfg_r.offset_y        <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tsdc_pkg::REG_X_TILT_GAIN: cfg_r.x_tilt_gain     <= cfg_data[5:0];
        tsdc_pkg::REG_STEER_GAIN:  cfg_r.steer_gain_q8_8 <= cfg_data[11:0];
        tsdc_pkg::REG_OFFSET_X:    cfg_r.offset_x        <= cfg_data[9:0];
        tsdc_pkg::REG_OFFSET_Y:    cfg_r.offset_y        <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;

  assign sx = $signed({sum_x_r[10], sum_x_r}) + $signed({{4{in_data.accel_x_high[7]}},
                                                         in_data.accel_x_high});
  assign sy = $signed({sum_y_r[10], sum_y_r}) + $signed({{4{in_data.accel_y_high[7]}},
                                                         in_data.accel_y_high});

  tsdc_calc u_calc (
    .cfg         (cfg_r),
    .sx          (sx),
    .sy          (sy),
    .pot_level   (in_data.pot_level),
    .servo_width (servo_calc),
    .drive_width (drive_calc),
    .below_move  (below_move)
  );

  assign ticks_inc = (buzz_ticks_r == 6'd63) ? buzz_ticks_r : buzz_ticks_r + 6'd1;

  always_comb begin
    sample_count_nxt = sample_count_r;
    sum_x_nxt        = sum_x_r;
    sum_y_nxt        = sum_y_r;
    moving_nxt       = moving_r;
    phase_on_nxt     = phase_on_r;
    buzz_ticks_nxt   = buzz_ticks_r;
    buzz_nxt         = buzz_r;
    last_servo_nxt   = last_servo_r;
    last_drive_nxt   = last_drive_r;
    out_valid_nxt    = out_valid_r & out_stall;
    out_data_nxt     = out_data_r;

    if (in_accept) begin
      if (in_data.func == tsdc_pkg::FUNC_SAMPLE) begin
        if (sample_count_r != tsdc_pkg::LAST_SAMPLE) begin
          sum_x_nxt        = sx[10:0];
          sum_y_nxt        = sy[10:0];
          sample_count_nxt = sample_count_r + 2'd1;
        end else begin
          sample_count_nxt = '0;
          sum_x_nxt        = '0;
          sum_y_nxt        = '0;
          last_servo_nxt   = servo_calc;
          if (in_data.drive_disable) begin
            moving_nxt     = 1'b0;
            last_drive_nxt = 12'(tsdc_pkg::PW_NEUT);
          end else begin
            moving_nxt     = below_move;
            last_drive_nxt = drive_calc;
          end
          if (!moving_nxt) begin
            buzz_nxt       = 1'b0;
            buzz_ticks_nxt = '0;
          end
          out_valid_nxt = 1'b1;
        end
      end else begin
        if (moving_r) begin
          buzz_ticks_nxt = ticks_inc;
          if (phase_on_r && ticks_inc >= 6'(tsdc_pkg::BUZZ_ON_TICKS)) begin
            buzz_nxt       = 1'b0;
            phase_on_nxt   = 1'b0;
            buzz_ticks_nxt = '0;
          end else if (!phase_on_r && ticks_inc >= 6'(tsdc_pkg::BUZZ_OFF_TICKS)) begin
            buzz_nxt       = 1'b1;
            phase_on_nxt   = 1'b1;
            buzz_ticks_nxt = '0;
          end
        end else begin
          buzz_nxt       = 1'b0;
          buzz_ticks_nxt = '0;
        end
        out_valid_nxt = 1'b1;
      end
      out_data_nxt.kind            = in_data.func;
      out_data_nxt.servo_width     = last_servo_nxt;
      out_data_nxt.drive_width     = last_drive_nxt;
      out_data_nxt.is_moving       = moving_nxt;
      out_data_nxt.buzzer_sounding = buzz_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= '0;
      sum_x_r        <= '0;
      sum_y_r        <= '0;
      moving_r       <= 1'b0;
      phase_on_r     <= 1'b0;
      buzz_ticks_r   <= '0;
      buzz_r         <= 1'b0;
      last_servo_r   <= 12'(tsdc_pkg::SERVO_MID);
      last_drive_r   <= 12'(tsdc_pkg::PW_NEUT);
      out_valid_r    <= 1'b0;
    end else begin
      sample_count_r <= sample_count_nxt;
      sum_x_r        <= sum_x_nxt;
      sum_y_r        <= sum_y_nxt;
      moving_r       <= moving_nxt;
      phase_on_r     <= phase_on_nxt;
      buzz_ticks_r   <= buzz_ticks_nxt;
      buzz_r         <= buzz_nxt;
      last_servo_r   <= last_servo_nxt;
      last_drive_r   <= last_drive_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // buzzer can only sound while the car is moving
  a_buzz_needs_moving: assert property (@(posedge clk) disable iff (!rst_n)
    buzz_r |-> moving_r)
    else $error("buzzer on while not moving");

  // buzzer counter never passes the longer phase
  a_ticks_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    buzz_ticks_r <= 6'(tsdc_pkg::BUZZ_OFF_TICKS))
    else $error("buzzer tick count out of range");

  a_servo_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.servo_width >= 12'(tsdc_pkg::PW_LEFT) &&
                     out_data_r.servo_width <= 12'(tsdc_pkg::SERVO_HI)))
    else $error("steering width out of range");

  a_moving_drive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.is_moving) |->
      out_data_r.drive_width < 12'(tsdc_pkg::PW_NEUT - tsdc_pkg::MOVE_MARGIN))
    else $error("moving reported with drive near neutral");

  // a fourth sample returns the group counter to its start
  a_group_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_data.func == tsdc_pkg::FUNC_SAMPLE &&
     sample_count_r == tsdc_pkg::LAST_SAMPLE) |=> (sample_count_r == 2'd0 && out_valid_r))
    else $error("sample group did not close");

endmodule
